>>> hw/rtl/memristor_drift_step_macros.svh
// Assertion macros for the memristor drift step block.
// No dependencies; included by the checker.
`ifndef MEMRISTOR_DRIFT_STEP_MACROS_SVH
`define MEMRISTOR_DRIFT_STEP_MACROS_SVH

// same-cycle implication
`define MDS_ASSERT_IMP(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("mds check failed");

// next-cycle implication
`define MDS_ASSERT_NXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("mds check failed");

`endif

>>> hw/rtl/mds_pkg.sv
// Shared constants for the memristor drift step block.
// No dependencies.
package mds_pkg;
	localparam int STATE_FRAC_BITS = 40;
	localparam int VOLT_FRAC_BITS  = 12;
	localparam int X_W             = STATE_FRAC_BITS + 1;
	localparam int XR_LSB          = STATE_FRAC_BITS - 24;
	localparam int V_SHIFT         = 56 - VOLT_FRAC_BITS;
	localparam logic [X_W-1:0] ONE_X = X_W'(1) << STATE_FRAC_BITS;
	localparam logic [24:0] ONE_24   = 25'd16777216;
	localparam logic [63:0] NS_SCALE = 64'd1000000000;
	localparam logic [29:0] G_MAX    = 30'd1000000000;

	localparam logic [1:0] REG_R_ON      = 2'd0;
	localparam logic [1:0] REG_R_OFF     = 2'd1;
	localparam logic [1:0] REG_STEP_GAIN = 2'd2;
endpackage

>>> hw/rtl/memristor_drift_step.sv
// Top level of the memristor drift step block: sequencer and shared add/shift unit.
// Depends on mds_pkg.
//
// One item is in flight at a time; in_ready is high only while idle. A voltage item runs
// three 64-step restoring divisions (current, and the two conductance terms) and ten
// shift-add multiplies that stop once the multiplier runs out of set bits, all on one
// shared 64-bit adder; a load item runs only the two conductance multiplies and divisions.
// The result sits in an output register, so the block goes idle once it is placed there.
module memristor_drift_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [39:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic signed [15:0] voltage,
	input  logic [mds_pkg::X_W-1:0] state_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [mds_pkg::X_W-1:0] state_out,
	output logic [29:0] conductance_ns
);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	localparam logic [3:0] PH_RON  = 4'd0;
	localparam logic [3:0] PH_ROFF = 4'd1;
	localparam logic [3:0] PH_IA   = 4'd2;
	localparam logic [3:0] PH_D2   = 4'd3;
	localparam logic [3:0] PH_D4   = 4'd4;
	localparam logic [3:0] PH_D6   = 4'd5;
	localparam logic [3:0] PH_T    = 4'd6;
	localparam logic [3:0] PH_GH   = 4'd7;
	localparam logic [3:0] PH_GL   = 4'd8;
	localparam logic [3:0] PH_GA   = 4'd9;
	localparam logic [3:0] PH_DA   = 4'd10;
	localparam logic [3:0] PH_GB   = 4'd11;
	localparam logic [3:0] PH_DB   = 4'd12;

	logic [1:0]  st_q;
	logic [3:0]  ph_q;
	logic [15:0] r_on_q, r_off_q;
	logic [39:0] gain_q;
	logic [mds_pkg::X_W-1:0] x_q;
	logic        neg_q;
	logic [15:0] mag_q;
	logic [40:0] rr_q;
	logic [59:0] ia_q;
	logic [24:0] d2_q, d4_q, w_q;
	logic [39:0] t_q;
	logic [63:0] p_q;
	logic [54:0] ga_q;
	logic [29:0] g_q;
	logic        out_valid_q;
	logic [mds_pkg::X_W-1:0] state_out_q;
	logic [29:0] cond_q;

	// shared unit
	logic        div_mode_q;
	logic [63:0] acc_q, num_q;
	logic [24:0] mplier_q;
	logic [40:0] dvs_q, rem_q;
	logic [6:0]  cnt_q;

	logic [24:0] xr, xr_c, d;
	logic [25:0] two_x;
	logic [41:0] rs;
	logic [63:0] opa, opb;
	logic [64:0] sum;
	logic        geq, unit_done;
	logic [63:0] dx_full;
	logic [51:0] dx;
	logic [52:0] nx;
	logic [55:0] g_sum;
	logic [15:0] on_eff, off_eff;
	logic [16:0] mag_c;

	assign xr    = x_q[mds_pkg::X_W-1:mds_pkg::XR_LSB];
	assign xr_c  = mds_pkg::ONE_24 - xr;
	assign two_x = {xr, 1'b0};
	assign d     = (two_x >= {1'b0, mds_pkg::ONE_24}) ? 25'(two_x - {1'b0, mds_pkg::ONE_24})
	                                               : 25'({1'b0, mds_pkg::ONE_24} - two_x);
	assign on_eff  = (r_on_q == 16'd0) ? 16'd1 : r_on_q;
	assign off_eff = (r_off_q == 16'd0) ? 16'd1 : r_off_q;
	assign mag_c   = voltage[15] ? (17'h10000 - {1'b0, voltage}) : {1'b0, voltage};

	assign rs  = {rem_q, num_q[63]};
	assign opa = div_mode_q ? {22'd0, rs} : acc_q;
	assign opb = div_mode_q ? ~{23'd0, dvs_q} : num_q;
	assign sum = {1'b0, opa} + {1'b0, opb} + 65'(div_mode_q);
	assign geq = sum[64];
	assign unit_done = div_mode_q ? cnt_q[6] : (mplier_q == 25'd0);

	assign dx_full = p_q + {20'd0, acc_q[63:20]};
	assign dx      = dx_full[63:12];
	assign nx      = 53'(x_q) + 53'(dx);
	assign g_sum   = 56'(ga_q) + 56'(acc_q[54:0]);

	assign in_ready       = (st_q == ST_IDLE);
	assign out_valid      = out_valid_q;
	assign state_out      = state_out_q;
	assign conductance_ns = cond_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_on_q  <= 16'd100;
			r_off_q <= 16'd16000;
			gain_q  <= 40'd10995116;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mds_pkg::REG_R_ON:      r_on_q  <= cfg_data[15:0];
				mds_pkg::REG_R_OFF:     r_off_q <= cfg_data[15:0];
				mds_pkg::REG_STEP_GAIN: gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ph_q        <= PH_RON;
			x_q         <= mds_pkg::ONE_X >> 1;
			out_valid_q <= 1'b0;
			div_mode_q  <= 1'b0;
		end else begin
			if (st_q == ST_OUT && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						st_q <= ST_SETUP;
						if (cmd) begin
							x_q  <= (state_value > mds_pkg::ONE_X) ? mds_pkg::ONE_X : state_value;
							ph_q <= PH_GA;
						end else begin
							neg_q <= voltage[15];
							mag_q <= mag_c[15:0];
							ph_q  <= PH_RON;
						end
					end
				end
				ST_SETUP: begin
					st_q  <= ST_RUN;
					cnt_q <= 7'd0;
					rem_q <= 41'd0;
					unique case (ph_q)
						PH_RON: begin
							div_mode_q <= 1'b0; acc_q <= 64'd0;
							num_q <= 64'(r_on_q); mplier_q <= xr;
						end
						PH_ROFF: begin
							div_mode_q <= 1'b0;
							num_q <= 64'(r_off_q); mplier_q <= xr_c;
						end
						PH_IA: begin
							div_mode_q <= 1'b1; acc_q <= 64'd0;
							num_q <= 64'(mag_q) << mds_pkg::V_SHIFT;
							dvs_q <= (rr_q == 41'd0) ? 41'd1 : rr_q;
						end
						PH_D2: begin
							div_mode_q <= 1'b0; acc_q <= 64'd0;
							num_q <= 64'(d); mplier_q <= d;
						end
						PH_D4: begin
							div_mode_q <= 1'b0; acc_q <= 64'd0;
							num_q <= 64'(d2_q); mplier_q <= d2_q;
						end
						PH_D6: begin
							div_mode_q <= 1'b0; acc_q <= 64'd0;
							num_q <= 64'(d4_q); mplier_q <= d2_q;
						end
						PH_T: begin
							div_mode_q <= 1'b0; acc_q <= 64'd0;
							num_q <= 64'(ia_q); mplier_q <= w_q;
						end
						PH_GH: begin
							div_mode_q <= 1'b0; acc_q <= 64'd0;
							num_q <= 64'(t_q); mplier_q <= 25'(gain_q[39:20]);
						end
						PH_GL: begin
							div_mode_q <= 1'b0; acc_q <= 64'd0;
							num_q <= 64'(t_q); mplier_q <= 25'(gain_q[19:0]);
						end
						PH_GA, PH_GB: begin
							div_mode_q <= 1'b0; acc_q <= 64'd0;
							num_q <= mds_pkg::NS_SCALE;
							mplier_q <= (ph_q == PH_GA) ? xr : xr_c;
						end
						PH_DA, PH_DB: begin
							div_mode_q <= 1'b1; acc_q <= 64'd0;
							num_q <= acc_q;
							dvs_q <= 41'((ph_q == PH_DA) ? on_eff : off_eff);
						end
						default: ;
					endcase
				end
				ST_RUN: begin
					if (!unit_done) begin
						num_q <= num_q << 1;
						if (div_mode_q) begin
							rem_q <= geq ? sum[40:0] : rs[40:0];
							acc_q <= {acc_q[62:0], geq};
							cnt_q <= cnt_q + 7'd1;
						end else begin
							if (mplier_q[0])
								acc_q <= sum[63:0];
							mplier_q <= mplier_q >> 1;
						end
					end else begin
						st_q <= ST_SETUP;
						ph_q <= ph_q + 4'd1;
						unique case (ph_q)
							PH_ROFF: rr_q <= acc_q[40:0];
							PH_IA:   ia_q <= acc_q[59:0];
							PH_D2:   d2_q <= acc_q[48:24];
							PH_D4:   d4_q <= acc_q[48:24];
							PH_D6:   w_q  <= mds_pkg::ONE_24 - acc_q[48:24];
							PH_T:    t_q  <= acc_q[63:24];
							PH_GH:   p_q  <= acc_q;
							PH_GL: begin
								if (!neg_q)
									x_q <= (nx > 53'(mds_pkg::ONE_X)) ? mds_pkg::ONE_X
									                                  : nx[mds_pkg::X_W-1:0];
								else
									x_q <= (53'(dx) >= 53'(x_q)) ? '0
									       : mds_pkg::X_W'(53'(x_q) - 53'(dx));
							end
							PH_DA:   ga_q <= acc_q[54:0];
							PH_DB: begin
								g_q  <= g_sum[53:24];
								st_q <= ST_OUT;
							end
							default: ;
						endcase
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT && (!out_valid_q || out_ready)) begin
			state_out_q <= x_q;
			cond_q      <= g_q;
		end
	end
endmodule

>>> hw/rtl/mds_checker.sv
// Port-level checks for the memristor drift step block, bound to the top level.
// Depends on mds_pkg and memristor_drift_step_macros.svh.
`include "memristor_drift_step_macros.svh"

module mds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [mds_pkg::X_W-1:0] state_out,
	input logic [29:0] conductance_ns
);
	// a stalled result holds
	`MDS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(state_out))
	// busy after every input transfer
	`MDS_ASSERT_NXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready)
	`MDS_ASSERT_IMP(a_x_range, clk, arst_n, out_valid, state_out <= mds_pkg::ONE_X)
	`MDS_ASSERT_IMP(a_g_range, clk, arst_n, out_valid, conductance_ns <= mds_pkg::G_MAX)
endmodule

bind memristor_drift_step mds_checker u_mds_checker (.*);

>>> bench/memristor_drift_step_test.sv
// Self-checking bench for the memristor drift step block: queued driver, clocked monitor,
// built-in state/conductance predictor. Depends on mds_pkg and memristor_drift_step.
module memristor_drift_step_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic                    cmd;
		logic [15:0]             volt;
		logic [mds_pkg::X_W-1:0] sval;
	} drift_item_t;

	typedef struct {
		logic [mds_pkg::X_W-1:0] x;
		logic [29:0]             g;
	} drift_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = mds_pkg::REG_R_ON;
	logic [39:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = 1'b0;
	logic signed [15:0] voltage = '0;
	logic [mds_pkg::X_W-1:0] state_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [mds_pkg::X_W-1:0] state_out;
	logic [29:0] conductance_ns;

	memristor_drift_step DUT (.*);

	always #6 clk = ~clk;

	// predictor copy of the block's registers and state
	logic [63:0] m_ron, m_roff, m_gain, m_x;

	drift_item_t   pending_items[$];
	drift_result_t expected_results[$];
	int errors = 0;
	int n_sent = 0, n_checked = 0, n_loads = 0, n_cfg = 0;
	int snd_idle = 0, rcv_idle = 0;
	int hold_cycles = 0;
	logic taken = 1'b0;

	function automatic logic [63:0] joglekar_window(input logic [63:0] xr);
		logic [63:0] two, d, d2, d4, d6;
		two = xr << 1;
		d = (two >= 64'(mds_pkg::ONE_24)) ? two - 64'(mds_pkg::ONE_24)
		                                  : 64'(mds_pkg::ONE_24) - two;
		d2 = (d * d) >> 24;
		d4 = (d2 * d2) >> 24;
		d6 = (d4 * d2) >> 24;
		return 64'(mds_pkg::ONE_24) - d6;
	endfunction

	function automatic logic [29:0] conductance_of_state();
		logic [63:0] xr, on, off, a, b;
		xr = m_x >> mds_pkg::XR_LSB;
		on = (m_ron != 0) ? m_ron : 64'd1;
		off = (m_roff != 0) ? m_roff : 64'd1;
		a = (xr * mds_pkg::NS_SCALE) / on;
		b = ((64'(mds_pkg::ONE_24) - xr) * mds_pkg::NS_SCALE) / off;
		return 30'((a + b) >> 24);
	endfunction

	function automatic drift_result_t drift_predict(input drift_item_t it);
		drift_result_t res;
		logic [63:0] v16, mag, xr, r, ia, t, gh, gl, dx, nx;
		logic neg;
		if (it.cmd) begin
			m_x = (64'(it.sval) > 64'(mds_pkg::ONE_X)) ? 64'(mds_pkg::ONE_X) : 64'(it.sval);
		end else begin
			v16 = 64'(it.volt);
			neg = it.volt[15];
			mag = neg ? 64'h10000 - v16 : v16;
			xr = m_x >> mds_pkg::XR_LSB;
			r = m_ron * xr + m_roff * (64'(mds_pkg::ONE_24) - xr);
			if (r == 0)
				r = 1;
			ia = (mag << mds_pkg::V_SHIFT) / r;
			t = (ia * joglekar_window(xr)) >> 24;	// wraps at 64 bits, as the block does
			gh = m_gain >> 20;
			gl = m_gain & 64'hFFFFF;
			dx = (gh * t + ((gl * t) >> 20)) >> 12;
			if (!neg) begin
				nx = m_x + dx;
				m_x = (nx > 64'(mds_pkg::ONE_X)) ? 64'(mds_pkg::ONE_X) : nx;
			end else begin
				m_x = (dx >= m_x) ? 64'd0 : m_x - dx;
			end
		end
		res.x = mds_pkg::X_W'(m_x);
		res.g = conductance_of_state();
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			expected_results.push_back(drift_predict('{cmd, voltage, state_value}));
			n_sent++;
		end
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected transfer, state", state_out, 0);
			end else begin
				drift_result_t e;
				e = expected_results.pop_front();
				if (state_out !== e.x)
					report_mismatch("state_out", state_out, e.x);
				if (conductance_ns !== e.g)
					report_mismatch("conductance_ns", conductance_ns, e.g);
				n_checked++;
			end
		end
	end

	// sender
	always @(negedge clk) begin
		if (in_valid && !taken) begin
			in_valid <= 1'b1;
		end else if (pending_items.size() > 0 && $urandom_range(99) >= snd_idle) begin
			drift_item_t it;
			it = pending_items.pop_front();
			cmd <= it.cmd;
			voltage <= it.volt;
			state_value <= it.sval;
			in_valid <= 1'b1;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [39:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			mds_pkg::REG_R_ON:      m_ron = 64'(val[15:0]);
			mds_pkg::REG_R_OFF:     m_roff = 64'(val[15:0]);
			mds_pkg::REG_STEP_GAIN: m_gain = 64'(val);
			default:       ;
		endcase
		n_cfg++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_item(input logic c, input logic [15:0] v,
		input logic [mds_pkg::X_W-1:0] s);
		pending_items.push_back('{c, v, s});
		if (c)
			n_loads++;
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [mds_pkg::X_W-1:0] random_state();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(5))
			0: return mds_pkg::ONE_X;
			1: return mds_pkg::X_W'(r);	// may exceed one
			2: return mds_pkg::X_W'(r[39:0] >> $urandom_range(39));
			3: return mds_pkg::ONE_X - mds_pkg::X_W'(r[15:0]);
			default: return mds_pkg::X_W'(r[39:0]);
		endcase
	endfunction

	function automatic logic [15:0] random_voltage();
		case ($urandom_range(4))
			0: return 16'($urandom_range(4095));
			1: return -16'($urandom_range(4095));
			2: return 16'($urandom_range(15)) ^ {16{$urandom_range(1) == 1}};
			default: return 16'($urandom);
		endcase
	endfunction

	// random sequences: each item is a state load with odds of one in six, else a drive step
	task automatic queue_random(input int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(5) == 0)
				queue_item(1'b1, 16'($urandom), random_state());
			else
				queue_item(1'b0, random_voltage(), mds_pkg::X_W'({$urandom, $urandom}));
		end
	endtask

	task automatic random_config();
		logic [39:0] g;
		g = {8'($urandom), 32'($urandom)} >> $urandom_range(39);
		write_reg(mds_pkg::REG_R_ON, 40'($urandom_range(65535, 1)));
		write_reg(mds_pkg::REG_R_OFF, 40'($urandom_range(65535, 1)));
		write_reg(mds_pkg::REG_STEP_GAIN, g);
	endtask

	initial begin
		m_ron = 100;
		m_roff = 16000;
		m_gain = 10995116;
		m_x = 64'(mds_pkg::ONE_X) >> 1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part under reset settings
		queue_item(1'b0, 16'h0000, '0);	// zero voltage leaves x alone
		queue_item(1'b0, 16'h7FFF, '0);
		queue_item(1'b0, 16'h8000, '0);
		queue_item(1'b1, '0, mds_pkg::ONE_X >> 1);
		queue_item(1'b0, 16'hFFFF, {mds_pkg::X_W{1'b1}});
		queue_item(1'b0, 16'h0001, '0);
		queue_item(1'b1, 16'hFFFF, {mds_pkg::X_W{1'b1}});	// load above one
		queue_item(1'b0, 16'h7FFF, '0);
		queue_item(1'b1, '0, mds_pkg::ONE_X + 1);
		queue_item(1'b1, '0, '0);
		queue_item(1'b0, 16'h8000, '0);
		queue_item(1'b0, 16'h1000, '0);
		queue_item(1'b1, '0, mds_pkg::ONE_X);
		queue_item(1'b0, 16'hF000, '0);
		wait_drained();

		// extreme settings, zero resistances and an unknown index
		write_reg(mds_pkg::REG_R_ON, 40'd1);
		write_reg(mds_pkg::REG_R_OFF, 40'd65535);
		write_reg(mds_pkg::REG_STEP_GAIN, {40{1'b1}});
		write_reg(2'd3, 40'h12345);
		queue_item(1'b1, '0, mds_pkg::ONE_X >> 1);
		queue_item(1'b0, 16'h7FFF, '0);
		queue_item(1'b0, 16'h8000, '0);
		queue_item(1'b0, 16'h0100, '0);
		wait_drained();
		write_reg(mds_pkg::REG_R_ON, 40'd0);
		write_reg(mds_pkg::REG_R_OFF, 40'd0);
		write_reg(mds_pkg::REG_STEP_GAIN, 40'd0);
		queue_item(1'b1, '0, mds_pkg::ONE_X);
		queue_item(1'b0, 16'h7FFF, '0);
		queue_item(1'b1, '0, mds_pkg::ONE_X >> 3);
		queue_item(1'b0, 16'h8000, '0);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: begin snd_idle = 14; rcv_idle = 57; end
				1: begin snd_idle = 57; rcv_idle = 14; end
				default: begin snd_idle = 0; rcv_idle = 0; end
			endcase
			if (ph == 5) begin
				write_reg(mds_pkg::REG_R_ON, 40'd100);
				write_reg(mds_pkg::REG_R_OFF, 40'd16000);
				write_reg(mds_pkg::REG_STEP_GAIN, 40'd10995116);
			end else begin
				random_config();
			end
			if (ph == 2)
				hold_cycles = 3000;	// stall the output so the input backs up
			queue_random(62);
			wait_drained();
		end

		repeat (600) @(posedge clk);
		$display("Covered %0d transfers in (%0d loads), %0d checked, %0d register writes.",
			n_sent, n_loads, n_checked, n_cfg);
		if (errors == 0 && expected_results.size() == 0)
			$display("memristor_drift_step: match");
		else
			$display("memristor_drift_step: mismatch");
		$finish;
	end

	initial begin
		#30ms;
		$display("Timed out with %0d results outstanding.", expected_results.size());
		$display("memristor_drift_step: mismatch");
		$finish;
	end
endmodule
